[sv/fpa_pkg.sv]
// Package for the Q24.8 fixed-point ALU: operation codes and the word type
// that travels down the pipeline. No dependencies.
package fpa_pkg;

    localparam int WORD_W = 32;
    localparam int OP_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_FINT = 4'd8,
        OP_TINT = 4'd9
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] simple;
        logic              neg;
        logic              eq;
        logic              lt;
        logic              gt;
        logic              dz;
    } side_t;

endpackage

[sv/fpa_front.sv]
// Front stage of the Q24.8 ALU: compare flags, simple operations and operand
// magnitudes. Depends on fpa_pkg.
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [fpa_pkg::OP_W-1:0]    op,
    input  logic signed [31:0]          operand_a,
    input  logic signed [31:0]          operand_b,
    output logic                        out_valid,
    output fpa_pkg::side_t              side,
    output logic [31:0]                 mag_a,
    output logic [31:0]                 mag_b
);
    import fpa_pkg::*;

    side_t       side_next;
    logic        valid_reg;
    side_t       side_reg;
    logic [31:0] mag_a_reg;
    logic [31:0] mag_b_reg;

    always_comb
    begin
        side_next        = '0;
        side_next.op     = op;
        side_next.eq     = (operand_a == operand_b);
        side_next.lt     = (operand_a < operand_b);
        side_next.gt     = (operand_a > operand_b);
        side_next.neg    = operand_a[31] ^ operand_b[31];
        side_next.dz     = (op == OP_DIV) && (operand_b == '0);
        case (op)
            OP_ADD:  side_next.simple = operand_a + operand_b;
            OP_SUB:  side_next.simple = operand_a - operand_b;
            OP_MIN:  side_next.simple = side_next.lt ? operand_a : operand_b;
            OP_MAX:  side_next.simple = side_next.gt ? operand_a : operand_b;
            OP_INC:  side_next.simple = operand_a + 32'sd1;
            OP_DEC:  side_next.simple = operand_a - 32'sd1;
            OP_FINT: side_next.simple = operand_a <<< FRAC_BITS;
            OP_TINT: side_next.simple = operand_a >>> FRAC_BITS;
            default: side_next.simple = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg  <= side_next;
            mag_a_reg <= operand_a[31] ? 32'(-operand_a) : operand_a;
            mag_b_reg <= operand_b[31] ? 32'(-operand_b) : operand_b;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign mag_a     = mag_a_reg;
    assign mag_b     = mag_b_reg;

endmodule

[sv/fpa_mul.sv]
// Pipelined unsigned multiplier for the ALU: 32x32 product cut into two
// 32x16 partial products, then summed and shifted. No dependencies.
module fpa_mul #(
    parameter int FRAC_BITS = 8,
    parameter int DEPTH     = 34
) (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] mag_a,
    input  logic [31:0] mag_b,
    output logic [31:0] prod
);
    logic [47:0] lo_reg;
    logic [47:0] hi_reg;
    logic [63:0] sum;
    logic [31:0] pipe_reg [DEPTH-1];

    assign sum = {16'd0, lo_reg} + {hi_reg, 16'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg      <= mag_a * mag_b[15:0];
            hi_reg      <= mag_a * mag_b[31:16];
            pipe_reg[0] <= sum[FRAC_BITS +: 32];
            for (int i = 1; i < DEPTH - 1; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign prod = pipe_reg[DEPTH-2];

endmodule

[sv/fpa_div.sv]
// Pipelined restoring divider for the ALU: one quotient bit per stage over
// a (32+FRAC_BITS)-bit dividend. No dependencies.
module fpa_div #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] mag_a,
    input  logic [31:0] mag_b,
    output logic [31:0] quot
);
    localparam int N = 32 + FRAC_BITS;

    logic [N-1:0] num_reg [N+1];
    logic [32:0]  rem_reg [N+1];
    logic [31:0]  den_reg [N+1];
    logic [33:0]  trial   [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            trial[i] = {rem_reg[i], num_reg[i][N-1]} - {2'b00, den_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= {mag_a, FRAC_BITS'(0)};
            rem_reg[0] <= '0;
            den_reg[0] <= mag_b;
            for (int i = 0; i < N; i++)
            begin
                den_reg[i+1] <= den_reg[i];
                if (!trial[i][33])
                begin
                    rem_reg[i+1] <= trial[i][32:0];
                    num_reg[i+1] <= {num_reg[i][N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= {rem_reg[i][31:0], num_reg[i][N-1]};
                    num_reg[i+1] <= {num_reg[i][N-2:0], 1'b0};
                end
            end
        end
    end

    assign quot = num_reg[N][31:0];

endmodule

[sv/fixed_point_q24_8_alu.sv]
// Top level of the Q24.8 fixed-point ALU: front stage, multiplier and
// divider pipelines, final select. Depends on fpa_pkg and the fpa modules.
//
// channel   direction  handshake            fields
// input     in         in_valid / in_stall  op, operand_a, operand_b
// output    out        out_valid / out_stall result, flags
//
// One word enters per cycle while in_stall is low. The depth is set by the
// divider, one quotient bit per stage. All operations share that depth.
// Reset clears the valid bits only. A stall at the output freezes the whole
// pipeline unless the output register is empty.
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [fpa_pkg::OP_W-1:0] op,
    input  logic signed [31:0]       operand_a,
    input  logic signed [31:0]       operand_b,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [31:0]       result,
    output logic                     is_equal,
    output logic                     is_less,
    output logic                     is_greater,
    output logic                     divide_by_zero
);
    import fpa_pkg::*;

    localparam int DIV_D = 32 + FRAC_BITS + 1;

    logic        en;
    logic        f_valid;
    side_t       f_side;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] prod;
    logic [31:0] quot;
    logic        v_reg [DIV_D];
    side_t       s_reg [DIV_D];
    logic [31:0] mag;
    logic [31:0] res_next;
    logic        out_valid_reg;
    logic [31:0] result_reg;
    side_t       flags_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid), .op(op),
        .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(f_valid), .side(f_side), .mag_a(mag_a), .mag_b(mag_b)
    );

    fpa_mul #(.FRAC_BITS(FRAC_BITS), .DEPTH(DIV_D)) u_mul (
        .clk(clk), .en(en), .mag_a(mag_a), .mag_b(mag_b), .prod(prod)
    );

    fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .en(en), .mag_a(mag_a), .mag_b(mag_b), .quot(quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_D; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= f_valid;
            for (int i = 1; i < DIV_D; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            out_valid_reg <= v_reg[DIV_D-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0] <= f_side;
            for (int i = 1; i < DIV_D; i++)
            begin
                s_reg[i] <= s_reg[i-1];
            end
            result_reg <= res_next;
            flags_reg  <= s_reg[DIV_D-1];
        end
    end

    always_comb
    begin
        mag = (s_reg[DIV_D-1].op == OP_MUL) ? prod : quot;
        case (s_reg[DIV_D-1].op)
            OP_MUL:  res_next = s_reg[DIV_D-1].neg ? 32'(-mag) : mag;
            OP_DIV:  res_next = s_reg[DIV_D-1].dz ? '0
                              : (s_reg[DIV_D-1].neg ? 32'(-mag) : mag);
            default: res_next = s_reg[DIV_D-1].simple;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign result         = result_reg;
    assign is_equal       = flags_reg.eq;
    assign is_less        = flags_reg.lt;
    assign is_greater     = flags_reg.gt;
    assign divide_by_zero = flags_reg.dz;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({is_equal, is_less, is_greater}))
        else $error("compare flags not exclusive");
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result == '0)
        else $error("divide by zero with nonzero result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result))
        else $error("stalled word changed");

endmodule
